// ===== rtl/rraa_pkg.sv =====
// shared widths, constants and types for the round-robin adc average alarm
`timescale 1ns / 1ps

package rraa_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int SAMPLES_DEF  = 16;

	localparam int SMP_W  = 10;
	localparam int CHAN_W = 3;
	localparam int THR_W  = 10;
	localparam int WIN_W  = 9;

	localparam logic [SMP_W-1:0] FILL_LEVEL = 10'h266;

	localparam logic [THR_W-1:0]  THR_RST    = 10'd563;
	localparam logic [WIN_W-1:0]  WIN_RST    = 9'd10;
	localparam logic [CHAN_W-1:0] SUPPLY_RST = 3'd7;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WINDOW    = 2'd1,
		REG_SUPPLY    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	// load enables for the two divider stages
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} div_ctl_t;

endpackage

// ===== rtl/rraa_ram.sv =====
// generic single write port ram with registered read and read enable
`timescale 1ns / 1ps

module rraa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rraa_div.sv =====
// two stage divide of the window sum by the constant sample count
`timescale 1ns / 1ps

module rraa_div
	#(
	parameter int SAMPLES = 16,
	parameter int SUM_W = 14
) (
	input  logic                  clk,
	input  rraa_pkg::div_ctl_t    ctl,
	input  logic [SUM_W-1:0]      sum,
	output logic [rraa_pkg::SMP_W-1:0] mean
);
	import rraa_pkg::*;

	// reciprocal scaled by 2^SUM_W, quotient estimate is low by at most one
	localparam int MUL_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'((1 << SUM_W) / SAMPLES);
	localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(SAMPLES);

	logic [SUM_W-1:0]  sum_s2;
	logic [SUM_W-1:0]  sum_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [SMP_W-1:0]  q0;
	logic [SUM_W-1:0]  rem;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			sum_s2 <= sum;
		end
		if (ctl.ld_s3) begin
			sum_s3  <= sum_s2;
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(RECIP);
		end
	end

	always_comb begin
		q0   = prod_s3[SUM_W +: SMP_W];
		rem  = sum_s3 - SUM_W'(SUM_W'(q0) * DIVISOR);
		mean = q0 + SMP_W'(rem >= DIVISOR);
	end

endmodule

// ===== rtl/round_robin_adc_average_alarm_top.sv =====
// round-robin multichannel moving average with low supply alarm
//
//  port group   dir  handshake               payload
//  cfg (apb)    in   psel/penable, pready=1  paddr, pwdata, prdata
//  in           in   in_valid / in_ready     sample
//  out          out  out_valid / out_ready   channel, latest, average, alarm,
//                                            alarm_start, alarm_stop
//
// one transaction per cycle sustained unless the output stalls; the path
// from accept to output valid: ram read at accept, sum update, reciprocal
// multiply, quotient fix and alarm compare into the output register.
// each stage holds its own valid bit, so bubbles close up while the output
// is stalled. reset needs no clearing pass: a fill flag marks the first
// sweep through the sample ram, during which old samples read as 0x266.
`timescale 1ns / 1ps

module round_robin_adc_average_alarm_top #(
	parameter int CHANNELS = rraa_pkg::CHANNELS_DEF,
	parameter int SAMPLES  = rraa_pkg::SAMPLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rraa_pkg::PADDR_W-1:0] paddr,
	input  logic [rraa_pkg::PDATA_W-1:0] pwdata,
	output logic [rraa_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rraa_pkg::SMP_W-1:0]   sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rraa_pkg::CHAN_W-1:0]  channel,
	output logic [rraa_pkg::SMP_W-1:0]   latest,
	output logic [rraa_pkg::SMP_W-1:0]   average,
	output logic                         alarm,
	output logic                         alarm_start,
	output logic                         alarm_stop
);
	import rraa_pkg::*;

	localparam int DEPTH  = CHANNELS * SAMPLES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W  = $clog2(SAMPLES * 1023 + 1);
	localparam logic [SUM_W-1:0]  SUM_RST = SUM_W'(SAMPLES * 32'h266);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
	localparam logic [CH_W-1:0]   CH_LAST = CH_W'(CHANNELS - 1);

	// configuration registers
	logic [THR_W-1:0]  thr_q;
	logic [WIN_W-1:0]  win_q;
	logic [CHAN_W-1:0] supply_q;
	reg_idx_t          reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RST;
			win_q    <= WIN_RST;
			supply_q <= SUPPLY_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_THRESHOLD: thr_q    <= pwdata[THR_W-1:0];
				REG_WINDOW:    win_q    <= pwdata[WIN_W-1:0];
				REG_SUPPLY:    supply_q <= pwdata[CHAN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = PDATA_W'(thr_q);
			REG_WINDOW:    prdata = PDATA_W'(win_q);
			REG_SUPPLY:    prdata = PDATA_W'(supply_q);
			default:       prdata = '0;
		endcase
	end

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;
	logic accept, s1_move;

	assign ld_out   = !out_valid_q || out_ready;
	assign ld_s4    = !v_s4 || ld_out;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;
	assign accept   = in_valid && in_ready;
	assign s1_move  = v_s1 && ld_s2;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1        <= in_valid;
			if (ld_s2)  v_s2        <= v_s1;
			if (ld_s3)  v_s3        <= v_s2;
			if (ld_s4)  v_s4        <= v_s3;
			if (ld_out) out_valid_q <= v_s4;
		end
	end

	// round-robin pointers; ram is laid out slot-major so its address just counts
	logic [ADDR_W-1:0] addr_q;
	logic [CH_W-1:0]   ch_q;
	logic              filled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			ch_q     <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			addr_q <= (addr_q == ADDR_LAST) ? '0 : addr_q + 1'b1;
			ch_q   <= (ch_q == CH_LAST) ? '0 : ch_q + 1'b1;
			if (addr_q == ADDR_LAST) begin
				filled_q <= 1'b1;
			end
		end
	end

	// stage 1: old sample out of ram, running sum update
	logic [ADDR_W-1:0] addr_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [SMP_W-1:0]  smp_s1;
	logic              fill_s1;
	logic              byp_s1;
	logic [SMP_W-1:0]  byp_data_s1;
	logic [SMP_W-1:0]  ram_rdata;
	logic [SMP_W-1:0]  old_smp;
	logic [SUM_W-1:0]  sum_new;
	logic [SUM_W-1:0]  sums_q [CHANNELS];

	rraa_ram #(
		.WIDTH (SMP_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (s1_move),
		.waddr(addr_s1),
		.wdata(smp_s1),
		.re   (accept),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= addr_q;
			ch_s1       <= ch_q;
			smp_s1      <= sample;
			fill_s1     <= !filled_q;
			// read and write of the same entry in the same cycle
			byp_s1      <= s1_move && (addr_s1 == addr_q);
			byp_data_s1 <= smp_s1;
		end
	end

	always_comb begin
		if (byp_s1) begin
			old_smp = byp_data_s1;
		end else if (fill_s1) begin
			old_smp = FILL_LEVEL;
		end else begin
			old_smp = ram_rdata;
		end
		sum_new = sums_q[ch_s1] - SUM_W'(old_smp) + SUM_W'(smp_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= SUM_RST;
			end
		end else if (s1_move) begin
			sums_q[ch_s1] <= sum_new;
		end
	end

	// stages 2 and 3: divide by the sample count
	div_ctl_t         div_ctl;
	logic [SMP_W-1:0] mean_s3;
	logic [CH_W-1:0]  ch_s2, ch_s3, ch_s4;
	logic [SMP_W-1:0] smp_s2, smp_s3, smp_s4;
	logic [SMP_W-1:0] mean_s4;

	assign div_ctl.ld_s2 = s1_move;
	assign div_ctl.ld_s3 = ld_s3 && v_s2;

	rraa_div #(
		.SAMPLES(SAMPLES),
		.SUM_W  (SUM_W)
	) u_div (
		.clk (clk),
		.ctl (div_ctl),
		.sum (sum_new),
		.mean(mean_s3)
	);

	always_ff @(posedge clk) begin
		if (div_ctl.ld_s2) begin
			ch_s2  <= ch_s1;
			smp_s2 <= smp_s1;
		end
		if (div_ctl.ld_s3) begin
			ch_s3  <= ch_s2;
			smp_s3 <= smp_s2;
		end
		if (ld_s4 && v_s3) begin
			ch_s4   <= ch_s3;
			smp_s4  <= smp_s3;
			mean_s4 <= mean_s3;
		end
	end

	// stage 4: hysteresis compare into the output register
	logic              alarm_q;
	logic              is_supply;
	logic [THR_W-1:0]  low_lim;
	logic [THR_W:0]    high_lim;
	logic              set_alarm, clr_alarm;
	logic              out_move;

	assign out_move = ld_out && v_s4;

	always_comb begin
		is_supply = (CHAN_W'(ch_s4) == supply_q);
		low_lim   = (thr_q >= THR_W'(win_q)) ? thr_q - THR_W'(win_q) : '0;
		high_lim  = (THR_W + 1)'(thr_q) + (THR_W + 1)'(win_q);
		set_alarm = is_supply && !alarm_q && (mean_s4 < low_lim);
		clr_alarm = is_supply && alarm_q && ((THR_W + 1)'(mean_s4) >= high_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= 1'b0;
		end else if (out_move) begin
			if (set_alarm) begin
				alarm_q <= 1'b1;
			end else if (clr_alarm) begin
				alarm_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_move) begin
			channel     <= CHAN_W'(ch_s4);
			latest      <= smp_s4;
			average     <= mean_s4;
			alarm       <= (alarm_q || set_alarm) && !clr_alarm;
			alarm_start <= set_alarm;
			alarm_stop  <= clr_alarm;
		end
	end

endmodule

// ===== test/round_robin_adc_average_alarm_top_tb.sv =====
// testbench for the round-robin adc average alarm: directed table, then random phases
`timescale 1ns / 1ps

module round_robin_adc_average_alarm_top_tb;
	import rraa_pkg::*;

	localparam int CHANNELS     = CHANNELS_DEF;
	localparam int SAMPLES      = SAMPLES_DEF;
	localparam int LATENCY      = 5;
	localparam int RANDOM_ITEMS = 526;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [SMP_W-1:0]  latest;
		logic [SMP_W-1:0]  average;
		logic              alarm;
		logic              alarm_start;
		logic              alarm_stop;
	} avg_result_t;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_SETTING
	} row_kind_t;

	typedef enum logic [1:0] {
		MODE_UNIFORM,
		MODE_SWING,
		MODE_BAND,
		MODE_EXTREME
	} stim_mode_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] value;
		logic        typed;
		avg_result_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [SMP_W-1:0]   sample;
	logic               out_valid;
	logic               out_ready;
	logic [CHAN_W-1:0]  channel;
	logic [SMP_W-1:0]   latest;
	logic [SMP_W-1:0]   average;
	logic               alarm;
	logic               alarm_start;
	logic               alarm_stop;

	round_robin_adc_average_alarm_top #(
		.CHANNELS(CHANNELS),
		.SAMPLES (SAMPLES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.channel    (channel),
		.latest     (latest),
		.average    (average),
		.alarm      (alarm),
		.alarm_start(alarm_start),
		.alarm_stop (alarm_stop)
	);

	// window model of the block
	logic [SMP_W-1:0]  win_mem [CHANNELS][SAMPLES];
	logic [15:0]       chan_sum [CHANNELS];
	int                chan_ptr;
	int                slot_ptr;
	logic              alarm_model;
	logic [THR_W-1:0]  thr_model;
	logic [WIN_W-1:0]  win_model;
	logic [CHAN_W-1:0] supply_model;

	avg_result_t pending_means [$];
	stim_row_t   dir_rows [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// one step of the window: store, update sum, mean, alarm, pointers
	function automatic avg_result_t advance_window(input logic [SMP_W-1:0] smp);
		avg_result_t  res;
		logic [SMP_W-1:0] mean;
		logic [SMP_W:0]   low_lim;
		logic [SMP_W:0]   high_lim;
		logic             start;
		logic             stop;
		start = 1'b0;
		stop  = 1'b0;
		chan_sum[chan_ptr] = chan_sum[chan_ptr] - 16'(win_mem[chan_ptr][slot_ptr]) + 16'(smp);
		win_mem[chan_ptr][slot_ptr] = smp;
		mean = SMP_W'(chan_sum[chan_ptr] / SAMPLES);
		if (chan_ptr == int'(supply_model)) begin
			if (alarm_model) begin
				// upper limit may pass full scale, then it never clears
				high_lim = {1'b0, thr_model} + (SMP_W+1)'(win_model);
				if ({1'b0, mean} >= high_lim) begin
					alarm_model = 1'b0;
					stop = 1'b1;
				end
			end else begin
				low_lim = (thr_model >= win_model) ? (SMP_W+1)'(thr_model - win_model) : '0;
				if ({1'b0, mean} < low_lim) begin
					alarm_model = 1'b1;
					start = 1'b1;
				end
			end
		end
		res.channel     = CHAN_W'(chan_ptr);
		res.latest      = smp;
		res.average     = mean;
		res.alarm       = alarm_model;
		res.alarm_start = start;
		res.alarm_stop  = stop;
		if (chan_ptr == CHANNELS - 1)
			slot_ptr = (slot_ptr == SAMPLES - 1) ? 0 : slot_ptr + 1;
		chan_ptr = (chan_ptr == CHANNELS - 1) ? 0 : chan_ptr + 1;
		return res;
	endfunction

	task automatic send_sample(input logic [SMP_W-1:0] val, input logic typed,
			input avg_result_t want);
		int          gap;
		avg_result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= val;
		do @(posedge clk); while (!in_ready);
		predicted = advance_window(val);
		pending_means.push_back(typed ? want : predicted);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	// apb write, then a read back on the next transfer
	task automatic program_register(input reg_idx_t idx, input logic [31:0] val);
		int          width;
		logic [31:0] mask;
		case (idx)
			REG_THRESHOLD: width = THR_W;
			REG_WINDOW:    width = WIN_W;
			default:       width = CHAN_W;
		endcase
		mask = (32'd1 << width) - 32'd1;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		// junk above the field has to be ignored
		pwdata  <= ($urandom() & ~mask) | (val & mask);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_THRESHOLD: thr_model = val[THR_W-1:0];
			REG_WINDOW:    win_model = val[WIN_W-1:0];
			default:       supply_model = val[CHAN_W-1:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (val & mask))
			flag_mismatch($sformatf("register %s read 0x%0h, want 0x%0h",
				idx.name(), prdata & mask, val & mask));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_sample_row(input logic [SMP_W-1:0] val, input logic typed,
			input avg_result_t want);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_SAMPLE;
		row.idx   = REG_NONE;
		row.value = 32'(val);
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	task automatic add_setting_row(input reg_idx_t idx, input logic [31:0] val);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_SETTING;
		row.idx   = idx;
		row.value = val;
		dir_rows.push_back(row);
	endtask

	initial begin : result_sink
		int          stall;
		avg_result_t want;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_means.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending, channel %0d", channel));
			end else begin
				want = pending_means.pop_front();
				check_field("channel", 16'(channel), 16'(want.channel));
				check_field("latest", 16'(latest), 16'(want.latest));
				check_field("average", 16'(average), 16'(want.average));
				check_field("alarm", 16'(alarm), 16'(want.alarm));
				check_field("alarm_start", 16'(alarm_start), 16'(want.alarm_start));
				check_field("alarm_stop", 16'(alarm_stop), 16'(want.alarm_stop));
			end
		end
	end

	initial begin : stimulus
		avg_result_t      fill_echo;
		avg_result_t      none;
		stim_mode_t       mode;
		logic [SMP_W-1:0] val;
		int               thr;
		int               win;
		int               sup;
		int               phase;
		int               sent;
		int               len;
		int               spread;
		int               level;
		bit               is_supply;

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		in_valid <= 1'b0;
		sample   <= '0;

		for (int c = 0; c < CHANNELS; c++) begin
			for (int s = 0; s < SAMPLES; s++)
				win_mem[c][s] = FILL_LEVEL;
			chan_sum[c] = 16'(SAMPLES) * 16'(FILL_LEVEL);
		end
		chan_ptr     = 0;
		slot_ptr     = 0;
		alarm_model  = 1'b0;
		thr_model    = THR_RST;
		win_model    = WIN_RST;
		supply_model = SUPPLY_RST;

		// a fill-level sample leaves the window sum untouched
		none              = '0;
		fill_echo         = '0;
		fill_echo.latest  = FILL_LEVEL;
		fill_echo.average = FILL_LEVEL;

		add_sample_row(FILL_LEVEL, 1'b1, fill_echo);
		add_sample_row(10'h000, 1'b0, none);
		add_sample_row(10'h3FF, 1'b0, none);
		add_sample_row(10'h155, 1'b0, none);
		add_sample_row(10'h2AA, 1'b0, none);
		add_sample_row(10'h001, 1'b0, none);
		add_sample_row(10'h3FE, 1'b0, none);
		fill_echo.channel = CHAN_W'(CHANNELS - 1);
		add_sample_row(FILL_LEVEL, 1'b1, fill_echo);
		// no hysteresis around 600: one low supply sample sets, one high sample clears
		add_setting_row(REG_THRESHOLD, 32'd600);
		add_setting_row(REG_WINDOW, 32'd0);
		add_setting_row(REG_SUPPLY, 32'd7);
		add_sample_row(10'h3FF, 1'b0, none);
		add_sample_row(10'h000, 1'b0, none);
		add_sample_row(10'h200, 1'b0, none);
		add_sample_row(10'h1FF, 1'b0, none);
		add_sample_row(10'h2AA, 1'b0, none);
		add_sample_row(10'h155, 1'b0, none);
		add_sample_row(10'h0F0, 1'b0, none);
		add_sample_row(10'h000, 1'b0, none);
		add_sample_row(10'h000, 1'b0, none);
		add_sample_row(10'h3FF, 1'b0, none);
		add_sample_row(10'h155, 1'b0, none);
		add_sample_row(10'h2AA, 1'b0, none);
		add_sample_row(10'h3C3, 1'b0, none);
		add_sample_row(10'h03C, 1'b0, none);
		add_sample_row(10'h266, 1'b0, none);
		add_sample_row(10'h3FF, 1'b0, none);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SETTING) begin
				wait_idle();
				program_register(dir_rows[i].idx, dir_rows[i].value);
			end else begin
				send_sample(dir_rows[i].value[SMP_W-1:0], dir_rows[i].typed, dir_rows[i].want);
			end
		end

		phase = 0;
		sent  = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			mode = MODE_SWING;
			case (phase)
				// low limit 512, upper limit past full scale: once set it stays
				0: begin thr = 1023; win = 511; sup = 0; end
				// clears on the first supply sample, then the zero floor keeps it off
				1: begin thr = 0; win = 0; sup = 0; end
				// lower limit floored at zero
				2: begin thr = 200; win = 511; sup = 7; end
				// clears only with a full window at full scale
				3: begin thr = 1023; win = 0; sup = 7; end
				default: begin
					if ($urandom_range(0, 3) == 0)
						thr = $urandom_range(0, 1) ? 1023 : 0;
					else
						thr = $urandom_range(0, 1023);
					win = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 511)
						: $urandom_range(0, 40);
					sup = $urandom_range(0, 7);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: mode = MODE_SWING;
						5, 6:          mode = MODE_BAND;
						7:             mode = MODE_UNIFORM;
						default:       mode = MODE_EXTREME;
					endcase
				end
			endcase
			program_register(REG_THRESHOLD, 32'(thr));
			program_register(REG_WINDOW, 32'(win));
			program_register(REG_SUPPLY, 32'(sup));
			no_idle = ($urandom_range(0, 3) == 0);
			len = $urandom_range(40, 80);
			if (len > RANDOM_ITEMS - sent)
				len = RANDOM_ITEMS - sent;
			repeat (len) begin
				is_supply = (chan_ptr == int'(supply_model));
				case (mode)
					// push the supply mean across whichever limit is next
					MODE_SWING: begin
						if (is_supply && $urandom_range(0, 15) != 0)
							val = alarm_model ? 10'h3FF : 10'h000;
						else
							val = SMP_W'($urandom_range(0, 1023));
					end
					// hover around the threshold on the supply channel
					MODE_BAND: begin
						if (is_supply) begin
							spread = int'(win_model) + 32;
							level  = int'(thr_model) + int'($urandom_range(0, 2 * spread)) - spread;
							if (level < 0)
								level = 0;
							else if (level > 1023)
								level = 1023;
							val = SMP_W'(level);
						end else begin
							val = SMP_W'($urandom_range(0, 1023));
						end
					end
					MODE_EXTREME: val = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
					default:      val = SMP_W'($urandom_range(0, 1023));
				endcase
				send_sample(val, 1'b0, none);
				sent++;
			end
			phase++;
		end

		no_idle = 1'b0;
		wait_idle();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rraa_pkg.sv
rtl/rraa_ram.sv
rtl/rraa_div.sv
rtl/round_robin_adc_average_alarm_top.sv
test/round_robin_adc_average_alarm_top_tb.sv
